FILE: hdl/plc_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by plc_cell, plc_ctrl and positional_list_engine.
`default_nettype none
package plc_pkg;
   localparam int STORE_DEPTH  = 16;
   localparam int CAPACITY_DEF = 16;
   localparam int CNT_W        = 5;
   localparam int POS_W        = 5;
   localparam int VAL_W        = 32;
   localparam int CMD_W        = 3;
   localparam int REQ_W        = 40;
   localparam int RSP_W        = 40;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND   = 3'd0,
      CMD_INSERT   = 3'd1,
      CMD_DEL_LAST = 3'd2,
      CMD_DEL_AT   = 3'd3,
      CMD_LIST     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_INS  = 2'd1,
      OP_DEL  = 2'd2,
      OP_ROT  = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LIST = 1'b1
   } state_type;

   // Broadcast to every cell: what to do and at which 0-based index.
   // For a rotate, idx is the last occupied cell.
   typedef struct packed {
      op_type                   op;
      logic [CNT_W-1:0]         idx;
      logic signed [VAL_W-1:0]  new_value;
   } cell_ctl_type;
endpackage
`default_nettype wire

FILE: hdl/plc_cell.sv
// One storage cell of the list chain: holds one entry and takes its
// left or right neighbor, the head or a new value as commanded. Uses plc_pkg.
`default_nettype none
module plc_cell #(
   parameter int IDX = 0
) (
   input  wire                                  clock,
   input  wire plc_pkg::cell_ctl_type           ctl,
   input  wire logic signed [plc_pkg::VAL_W-1:0] left_value,
   input  wire logic signed [plc_pkg::VAL_W-1:0] right_value,
   input  wire logic signed [plc_pkg::VAL_W-1:0] head_value,
   output logic signed [plc_pkg::VAL_W-1:0]      value
);
   import plc_pkg::*;

   localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         OP_INS: begin
            if (MyIdx > ctl.idx) begin
               value_in = left_value;
            end else if (MyIdx == ctl.idx) begin
               value_in = ctl.new_value;
            end
         end
         OP_DEL: begin
            if (MyIdx >= ctl.idx) begin
               value_in = right_value;
            end
         end
         OP_ROT: begin
            // close the ring at the last occupied cell
            if (MyIdx == ctl.idx) begin
               value_in = head_value;
            end else if (MyIdx < ctl.idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

FILE: hdl/plc_ctrl.sv
// Command decode, fill count, list sequencer and result register.
// Drives the cell chain through plc_pkg::cell_ctl_type. Uses plc_pkg.
`default_nettype none
module plc_ctrl #(
   parameter int CAP_EFF = plc_pkg::CAPACITY_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire logic [plc_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [plc_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [plc_pkg::VAL_W-1:0] req_item_value,
   input  wire logic signed [plc_pkg::VAL_W-1:0] head_value,
   output plc_pkg::cell_ctl_type                 ctl,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic signed [plc_pkg::VAL_W-1:0]      rsp_read_value,
   output logic [plc_pkg::CNT_W-1:0]             rsp_entry_count,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);
   import plc_pkg::*;

   localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAP_EFF);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        list_idx_ff, list_idx_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [VAL_W-1:0] out_value_ff, out_value_in;
   logic [CNT_W-1:0]        out_count_ff, out_count_in;
   status_type              out_status_ff, out_status_in;
   logic                    out_last_ff, out_last_in;

   logic out_free;
   logic accept;
   logic load;
   logic list_last;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign list_last  = (list_idx_ff == count_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      out_value_in  = out_value_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      load          = 1'b0;
      ctl.op        = OP_HOLD;
      ctl.idx       = '0;
      ctl.new_value = req_item_value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load          = 1'b1;
               out_value_in  = '0;
               out_status_in = STS_OK;
               out_last_in   = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_APPEND: begin
                     if (count_ff >= CapCnt) begin
                        out_status_in = STS_FULL;
                     end else begin
                        ctl.op   = OP_INS;
                        ctl.idx  = count_ff;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (count_ff >= CapCnt) begin
                        out_status_in = STS_FULL;
                     end else if (req_position == '0 ||
                                  {1'b0, req_position} > ({1'b0, count_ff} + 6'd1)) begin
                        out_status_in = STS_RANGE;
                     end else begin
                        ctl.op   = OP_INS;
                        ctl.idx  = req_position - POS_W'(1);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DEL_LAST: begin
                     if (count_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else begin
                        ctl.op   = OP_DEL;
                        ctl.idx  = count_ff - CNT_W'(1);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DEL_AT: begin
                     if (count_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else if (req_position == '0 || req_position > count_ff) begin
                        out_status_in = STS_RANGE;
                     end else begin
                        ctl.op   = OP_DEL;
                        ctl.idx  = req_position - POS_W'(1);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_LIST: begin
                     if (count_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else begin
                        // beats come from the list state
                        load        = 1'b0;
                        state_in    = ST_LIST;
                        list_idx_in = '0;
                     end
                  end
                  default: begin
                     out_status_in = STS_OK;
                  end
               endcase
               out_count_in = count_in;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               // emit the head and rotate the occupied cells by one
               load          = 1'b1;
               out_value_in  = head_value;
               out_count_in  = count_ff;
               out_status_in = STS_OK;
               out_last_in   = list_last;
               ctl.op        = OP_ROT;
               ctl.idx       = count_ff - CNT_W'(1);
               list_idx_in   = list_idx_ff + CNT_W'(1);
               if (list_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_read_value  = out_value_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCnt)
      else $error("fill count above capacity");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("fill count moved without a command");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff) ||
                  count_ff == $past(count_ff) + CNT_W'(1) ||
                  count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("fill count stepped by more than one");

   a_list_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIST |-> list_idx_ff < count_ff)
      else $error("list index past fill count");

   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST && out_free && list_last) |=> state_ff == ST_IDLE)
      else $error("list did not end after its last beat");
endmodule
`default_nettype wire

FILE: hdl/positional_list_engine.sv
// Top level of the positional list engine: a chain of plc_cell entries
// steered by plc_ctrl. Depends on plc_pkg, plc_cell and plc_ctrl.
//
//   channel  direction  beat contents
//   req_     in         tdata: cmd[2:0], position[7:3], item_value[39:8]
//   rsp_     out        tdata: read_value[31:0], entry_count[36:32],
//                       status[38:37], zero[39]; tlast: last_of_run
//
// Edit commands give one result beat each and are taken while the output is free.
// List gives one result beat per entry, and the occupied cells rotate one place
// per beat through the head cell, so the list is back in order at the end. No
// command is taken while the walk runs.
// Reset clears the fill count; cell contents are undefined until written.
// A stalled result holds in the output register and stalls both the input
// and the list walk.
`default_nettype none
module positional_list_engine #(
   parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [plc_pkg::REQ_W-1:0]   req_tdata,   // cmd, position, item_value
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [plc_pkg::RSP_W-1:0]  rsp_tdata,   // read_value, entry_count, status
   output logic                       rsp_tlast
);
   import plc_pkg::*;

   localparam int CapEff = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;

   logic [CMD_W-1:0]        req_cmd;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_item_value;
   logic signed [VAL_W-1:0] cell_value [CapEff];
   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]        rsp_entry_count;
   logic [1:0]              rsp_status;

   assign req_cmd        = req_tdata[CMD_W-1:0];
   assign req_position   = req_tdata[CMD_W+POS_W-1:CMD_W];
   assign req_item_value = req_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];

   plc_ctrl #(
      .CAP_EFF (CapEff)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .head_value      (cell_value[0]),
      .ctl             (ctl),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_tlast)
   );

   for (genvar g = 0; g < CapEff; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;
      // chain ends: the first cell never takes its left, the last holds on delete
      if (g == 0) begin : g_first
         assign left_v = ctl.new_value;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == CapEff - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      plc_cell #(
         .IDX (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[g])
      );
   end

   assign rsp_tdata = {1'b0, rsp_status, rsp_entry_count, rsp_read_value};
endmodule
`default_nettype wire

FILE: sim/plc_list_checker.sv
// Checker for the positional list engine: watches both streams, keeps its own copy
// of the list, and compares every result beat with the oldest predicted one.
// Depends on plc_pkg for widths, command codes and status codes.
module plc_list_checker
   import plc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   input  wire              req_tready,
   input  wire [REQ_W-1:0]  req_tdata,
   input  wire              rsp_tvalid,
   input  wire              rsp_tready,
   input  wire [RSP_W-1:0]  rsp_tdata,
   input  wire              rsp_tlast,
   output int               fail_count,
   output int               pending
);
   localparam int LIST_LIMIT = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;

   typedef struct {
      logic signed [VAL_W-1:0] read_value;
      logic [CNT_W-1:0]        entry_count;
      status_type              status;
      logic                    last_of_run;
   } list_result_type;

   logic signed [VAL_W-1:0] list_mem [STORE_DEPTH];
   int                      list_len;
   list_result_type         due_results [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      list_len   = 0;
   end

   function automatic status_type insert_entry(int pos, logic signed [VAL_W-1:0] val);
      if (list_len >= LIST_LIMIT) return STS_FULL;
      if (pos == 0 || pos > list_len + 1) return STS_RANGE;
      for (int i = list_len; i > pos - 1; i--) list_mem[i] = list_mem[i-1];
      list_mem[pos-1] = val;
      list_len++;
      return STS_OK;
   endfunction

   function automatic status_type remove_entry(int pos);
      if (list_len == 0) return STS_EMPTY;
      if (pos == 0 || pos > list_len) return STS_RANGE;
      for (int i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
      list_len--;
      return STS_OK;
   endfunction

   function automatic void push_result(logic signed [VAL_W-1:0] val, status_type st,
                                       logic last);
      list_result_type r;
      r.read_value  = val;
      r.entry_count = CNT_W'(list_len);
      r.status      = st;
      r.last_of_run = last;
      due_results.push_back(r);
   endfunction

   // Apply one command to the shadow list and queue the beats it should produce.
   function automatic void run_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                       logic signed [VAL_W-1:0] val);
      status_type st;
      st = STS_OK;
      case (op)
         CMD_APPEND:   st = insert_entry(list_len + 1, val);
         CMD_INSERT:   st = insert_entry(int'(pos), val);
         CMD_DEL_LAST: st = remove_entry(list_len);
         CMD_DEL_AT:   st = remove_entry(int'(pos));
         CMD_LIST: begin
            if (list_len == 0) begin
               push_result('0, STS_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  push_result(list_mem[i], STS_OK, i == list_len - 1);
            end
            return;
         end
         default: st = STS_OK;
      endcase
      push_result('0, st, 1'b1);
   endfunction

   always @(posedge clock) begin
      list_result_type exp_r;
      if (reset) begin
         list_len = 0;
         due_results.delete();
      end else begin
         // Check the outgoing beat first; a request taken on this edge cannot answer yet.
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result beat: data %h last %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               exp_r = due_results.pop_front();
               if (rsp_tdata[31:0] !== exp_r.read_value) begin
                  $error("read_value: expected %0d, got %0d", exp_r.read_value,
                         $signed(rsp_tdata[31:0]));
                  fail_count++;
               end
               if (rsp_tdata[36:32] !== exp_r.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                         rsp_tdata[36:32]);
                  fail_count++;
               end
               if (rsp_tdata[38:37] !== exp_r.status) begin
                  $error("status: expected %0d, got %0d", exp_r.status, rsp_tdata[38:37]);
                  fail_count++;
               end
               if (rsp_tlast !== exp_r.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d", exp_r.last_of_run, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            run_command(req_tdata[2:0], req_tdata[7:3], req_tdata[39:8]);
      end
      pending = due_results.size();
   end
endmodule

FILE: sim/tb_positional_list_engine.sv
// Testbench top for the positional list engine: clock, reset, bursty command
// stimulus, a stalling result sink and the final verdict.
// Depends on plc_pkg, positional_list_engine and plc_list_checker.
module tb_positional_list_engine;
   import plc_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES  = 120;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   wire               req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;  // cmd, position, item_value
   wire               rsp_tvalid;
   logic              rsp_tready = 1'b0;
   wire  [RSP_W-1:0]  rsp_tdata;        // read_value, entry_count, status, zero
   wire               rsp_tlast;        // last_of_run

   int fail_count;
   int pending;
   int items_sent = 0;
   int shadow_len = 0;

   positional_list_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   plc_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rough length tracking, only to steer positions toward valid ones.
   function automatic void track_length(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos);
      case (op)
         CMD_APPEND:   if (shadow_len < STORE_DEPTH) shadow_len++;
         CMD_INSERT:   if (shadow_len < STORE_DEPTH && pos != 0 && pos <= shadow_len + 1)
                          shadow_len++;
         CMD_DEL_LAST: if (shadow_len > 0) shadow_len--;
         CMD_DEL_AT:   if (shadow_len > 0 && pos != 0 && pos <= shadow_len) shadow_len--;
         default: ;
      endcase
   endfunction

   task automatic offer_item(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {val, pos, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      track_length(op, pos);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(bit for_insert);
      int top_pos;
      top_pos = for_insert ? shadow_len + 1 : ((shadow_len > 0) ? shadow_len : 1);
      if ($urandom_range(0, 6) == 0) return POS_W'($urandom_range(0, 31));
      return POS_W'($urandom_range(1, top_pos));
   endfunction

   // Grow phases lean on appends and inserts, shrink phases on deletes.
   function automatic logic [CMD_W-1:0] pick_command(bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return CMD_LIST;
      if (roll < 15) return CMD_W'($urandom_range(5, 7));
      if (growing) begin
         if (roll < 55) return CMD_APPEND;
         if (roll < 92) return CMD_INSERT;
         return (roll < 96) ? CMD_DEL_LAST : CMD_DEL_AT;
      end
      if (roll < 55) return CMD_DEL_LAST;
      if (roll < 92) return CMD_DEL_AT;
      return (roll < 96) ? CMD_APPEND : CMD_INSERT;
   endfunction

   // Result sink: rotate through stall patterns, plus long hold-offs mid-run.
   int sink_mode  = 0;
   int mode_left  = 0;
   int hold_left  = 0;
   int holds_done = 0;
   int sink_tick  = 0;

   always @(posedge clock) begin
      sink_tick <= sink_tick + 1;
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done < 2 && items_sent >= 150 + 200 * holds_done) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(16, 96);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (sink_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (sink_tick % 3 != 0);
         endcase
      end
   end

   initial begin
      int          burst_left;
      int          phase_left;
      int          gap;
      bit          growing;
      logic [CMD_W-1:0] op;

      burst_left = 0;
      phase_left = 0;
      growing    = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-list refusals, single-entry edits, range edges, odd codes.
      offer_item(CMD_LIST,     5'd0,  32'h0, 0);
      offer_item(CMD_DEL_LAST, 5'd0,  32'h0, 1);
      offer_item(CMD_DEL_AT,   5'd3,  32'h0, 0);
      offer_item(CMD_INSERT,   5'd0,  32'h1234_5678, 2);
      offer_item(CMD_INSERT,   5'd2,  32'h1234_5678, 0);
      offer_item(CMD_INSERT,   5'd1,  32'h7FFF_FFFF, 0);
      offer_item(CMD_DEL_AT,   5'd1,  32'h0, 1);
      offer_item(CMD_APPEND,   5'd31, 32'h8000_0000, 0);
      offer_item(CMD_APPEND,   5'd0,  32'hFFFF_FFFF, 0);
      offer_item(CMD_INSERT,   5'd3,  32'h0000_0000, 2);
      offer_item(CMD_INSERT,   5'd5,  32'hDEAD_BEEF, 0);
      offer_item(CMD_INSERT,   5'd1,  32'h5555_5555, 0);
      offer_item(CMD_INSERT,   5'd2,  32'hAAAA_AAAA, 1);
      offer_item(CMD_LIST,     5'd0,  32'h0, 0);
      offer_item(CMD_DEL_AT,   5'd0,  32'h0, 0);
      offer_item(CMD_DEL_AT,   5'd6,  32'h0, 0);
      offer_item(CMD_DEL_AT,   5'd31, 32'h0, 3);
      offer_item(CMD_DEL_AT,   5'd5,  32'h0, 0);
      offer_item(CMD_DEL_AT,   5'd2,  32'h0, 0);
      offer_item(CMD_DEL_LAST, 5'd16, 32'h0, 0);
      offer_item(3'd5,         5'd31, 32'hFFFF_FFFF, 0);
      offer_item(3'd6,         5'd16, 32'h8000_0000, 1);
      offer_item(3'd7,         5'd1,  32'h7FFF_FFFF, 0);
      offer_item(CMD_LIST,     5'd0,  32'h0, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            growing    = (shadow_len < 4) ? 1'b1 : ((shadow_len > 12) ? 1'b0 : !growing);
            phase_left = $urandom_range(20, 40);
         end
         phase_left--;
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
         end else begin
            gap = 0;
         end
         burst_left--;
         op = pick_command(growing);
         offer_item(op, pick_position(op == CMD_INSERT), pick_value(), gap);
      end

      req_tvalid <= 1'b0;
      // let the checker queue the beats of the last accepted item
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
